// File: hw/rtl/asip_pkg.sv
// Shared types, codes and lookup functions for the audio side-information parser.
package asip_pkg;

   localparam int ASIP_QUEUE_DEPTH = 4;

   localparam logic [12:0] VAL_UNUSED = 13'h1FFF;

   localparam logic [4:0] FID_MDB    = 5'd0;
   localparam logic [4:0] FID_PRIV   = 5'd1;
   localparam logic [4:0] FID_SCFSI  = 5'd2;
   localparam logic [4:0] FID_P23    = 5'd3;
   localparam logic [4:0] FID_BV     = 5'd4;
   localparam logic [4:0] FID_GAIN   = 5'd5;
   localparam logic [4:0] FID_SFC    = 5'd6;
   localparam logic [4:0] FID_SLEN1  = 5'd7;
   localparam logic [4:0] FID_SLEN2  = 5'd8;
   localparam logic [4:0] FID_WS     = 5'd9;
   localparam logic [4:0] FID_BT     = 5'd10;
   localparam logic [4:0] FID_MIX    = 5'd11;
   localparam logic [4:0] FID_SWPL   = 5'd12;
   localparam logic [4:0] FID_SWPS   = 5'd13;
   localparam logic [4:0] FID_TSEL   = 5'd14;
   localparam logic [4:0] FID_SBG    = 5'd15;
   localparam logic [4:0] FID_R0     = 5'd16;
   localparam logic [4:0] FID_R1     = 5'd17;
   localparam logic [4:0] FID_PRE    = 5'd18;
   localparam logic [4:0] FID_SFS    = 5'd19;
   localparam logic [4:0] FID_C1T    = 5'd20;

   typedef enum logic [4:0] {
      STEP_IDLE  = 5'd0,
      STEP_MDB   = 5'd1,
      STEP_PRIV  = 5'd2,
      STEP_SCFSI = 5'd3,
      STEP_P23   = 5'd4,
      STEP_BV    = 5'd5,
      STEP_GAIN  = 5'd6,
      STEP_SFC   = 5'd7,
      STEP_WS    = 5'd8,
      STEP_BT    = 5'd9,
      STEP_MIX   = 5'd10,
      STEP_TSEL  = 5'd11,
      STEP_SBG   = 5'd12,
      STEP_R0    = 5'd13,
      STEP_R1    = 5'd14,
      STEP_PRE   = 5'd15,
      STEP_SFS   = 5'd16,
      STEP_C1T   = 5'd17
   } step_type;

   typedef struct packed {
      step_type    step;
      logic [11:0] value;
      logic        gr;
      logic        ch;
      logic [1:0]  item;
      logic        sw;
      logic [1:0]  bk;
      logic        last;
      logic        fdone;
   } fld_evt_type;

   typedef struct packed {
      logic        gr;
      logic        ch;
      logic [4:0]  id;
      logic [1:0]  sub;
      logic [12:0] value;
      logic        fdone;
   } rsp_item_type;

   function automatic logic [3:0] asip_field_width(step_type step, logic stereo);
      logic [3:0] w;
      case (step)
         STEP_MDB:  w = 4'd9;
         STEP_PRIV: w = stereo ? 4'd3 : 4'd5;
         STEP_P23:  w = 4'd12;
         STEP_BV:   w = 4'd9;
         STEP_GAIN: w = 4'd8;
         STEP_SFC:  w = 4'd4;
         STEP_BT:   w = 4'd2;
         STEP_TSEL: w = 4'd5;
         STEP_SBG:  w = 4'd3;
         STEP_R0:   w = 4'd4;
         STEP_R1:   w = 4'd3;
         default:   w = 4'd1;
      endcase
      return w;
   endfunction

   function automatic logic [2:0] asip_slen1(logic [3:0] sfc);
      logic [2:0] s;
      case (sfc)
         4'd4, 4'd11, 4'd12, 4'd13: s = 3'd3;
         4'd5, 4'd6, 4'd7:          s = 3'd1;
         4'd8, 4'd9, 4'd10:         s = 3'd2;
         4'd14, 4'd15:              s = 3'd4;
         default:                   s = 3'd0;
      endcase
      return s;
   endfunction

   function automatic logic [1:0] asip_slen2(logic [3:0] sfc);
      logic [1:0] s;
      case (sfc)
         4'd1, 4'd5, 4'd8, 4'd11:                s = 2'd1;
         4'd2, 4'd6, 4'd9, 4'd12, 4'd14:         s = 2'd2;
         4'd3, 4'd7, 4'd10, 4'd13, 4'd15:        s = 2'd3;
         default:                                s = 2'd0;
      endcase
      return s;
   endfunction

   // Number of result items that one completed field expands into.
   function automatic logic [2:0] asip_count(fld_evt_type ev);
      logic [2:0] n;
      case (ev.step)
         STEP_SFC: n = 3'd3;
         STEP_WS:  n = ev.value[0] ? 3'd1 : 3'd5;
         STEP_MIX: n = 3'd3;
         STEP_TSEL: begin
            if (ev.sw && ev.item == 2'd1) begin
               n = 3'd2;
            end else if (!ev.sw && ev.item == 2'd2) begin
               n = 3'd4;
            end else begin
               n = 3'd1;
            end
         end
         STEP_SBG: n = (ev.item == 2'd2) ? 3'd3 : 3'd1;
         default:  n = 3'd1;
      endcase
      return n;
   endfunction

   // Result item number k of a completed field.
   function automatic rsp_item_type asip_result(fld_evt_type ev, logic [2:0] k);
      rsp_item_type r;
      r.gr    = ev.gr;
      r.ch    = ev.ch;
      r.id    = FID_MDB;
      r.sub   = 2'd0;
      r.value = {1'b0, ev.value};
      r.fdone = 1'b0;
      case (ev.step)
         STEP_MDB: begin
            r.gr = 1'b0;
            r.ch = 1'b0;
         end
         STEP_PRIV: begin
            r.gr = 1'b0;
            r.ch = 1'b0;
            r.id = FID_PRIV;
         end
         STEP_SCFSI: begin
            r.gr  = 1'b0;
            r.id  = FID_SCFSI;
            r.sub = ev.item;
         end
         STEP_P23:  r.id = FID_P23;
         STEP_BV:   r.id = FID_BV;
         STEP_GAIN: r.id = FID_GAIN;
         STEP_SFC: begin
            case (k)
               3'd1: begin
                  r.id    = FID_SLEN1;
                  r.value = {10'd0, asip_slen1(ev.value[3:0])};
               end
               3'd2: begin
                  r.id    = FID_SLEN2;
                  r.value = {11'd0, asip_slen2(ev.value[3:0])};
               end
               default: r.id = FID_SFC;
            endcase
         end
         STEP_WS: begin
            case (k)
               3'd1: begin
                  r.id    = FID_BT;
                  r.value = 13'd0;
               end
               3'd2: begin
                  r.id    = FID_MIX;
                  r.value = 13'd0;
               end
               3'd3: begin
                  r.id    = FID_SWPL;
                  r.value = VAL_UNUSED;
               end
               3'd4: begin
                  r.id    = FID_SWPS;
                  r.value = VAL_UNUSED;
               end
               default: r.id = FID_WS;
            endcase
         end
         STEP_BT: r.id = FID_BT;
         STEP_MIX: begin
            case (k)
               3'd1: begin
                  r.id    = FID_SWPL;
                  r.value = ev.value[0] ? 13'd8 : 13'd0;
               end
               3'd2: begin
                  r.id    = FID_SWPS;
                  r.value = ev.value[0] ? 13'd3 : 13'd0;
               end
               default: r.id = FID_MIX;
            endcase
         end
         STEP_TSEL: begin
            if (k == 3'd0) begin
               r.id  = FID_TSEL;
               r.sub = ev.item;
            end else if (ev.sw) begin
               r.id    = FID_TSEL;
               r.sub   = 2'd2;
               r.value = VAL_UNUSED;
            end else begin
               r.id    = FID_SBG;
               r.sub   = 2'(k - 3'd1);
               r.value = VAL_UNUSED;
            end
         end
         STEP_SBG: begin
            case (k)
               3'd1: begin
                  r.id    = FID_R0;
                  r.value = (ev.bk == 2'd2) ? 13'd8 : 13'd7;
               end
               3'd2: begin
                  r.id    = FID_R1;
                  r.value = (ev.bk == 2'd2) ? 13'd12 : 13'd13;
               end
               default: begin
                  r.id  = FID_SBG;
                  r.sub = ev.item;
               end
            endcase
         end
         STEP_R0:  r.id = FID_R0;
         STEP_R1:  r.id = FID_R1;
         STEP_PRE: r.id = FID_PRE;
         STEP_SFS: r.id = FID_SFS;
         STEP_C1T: begin
            r.id    = FID_C1T;
            r.fdone = ev.fdone;
         end
         default: r.id = FID_MDB;
      endcase
      return r;
   endfunction

endpackage

// File: hw/rtl/asip_front.sv
// Front end: takes bytes, slices them into side-information fields and queues each field.
module asip_front
   import asip_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic [1:0]  req_tuser,
   output logic        evt_push,
   output fld_evt_type evt_data,
   input  logic        evt_full
);

   step_type    step_ff, step_in, nxt_step;
   logic [11:0] acc_ff, acc_in;
   logic [3:0]  held_ff, held_in;
   logic        stereo_ff, stereo_in;
   logic        gr_ff, gr_in, nxt_gr;
   logic        ch_ff, ch_in, nxt_ch;
   logic        sw_ff, sw_in, nxt_sw;
   logic [1:0]  bk_ff, bk_in, nxt_bk;
   logic [1:0]  item_ff, item_in, nxt_item;
   logic [7:0]  byte_ff, byte_in;
   logic [3:0]  left_ff, left_in;

   logic [3:0]  width;
   logic [3:0]  need;
   logic [3:0]  take;
   logic [3:0]  left_after;
   logic [7:0]  bits;
   logic [11:0] acc_sh;
   logic [11:0] acc_new;
   logic [3:0]  held_new;
   logic        active;
   logic        complete;
   logic        stall;
   logic        last_of_byte;

   assign width    = asip_field_width(step_ff, stereo_ff);
   assign need     = width - held_ff;
   assign active   = (step_ff != STEP_IDLE) && (left_ff != 4'd0);
   assign take     = (need < left_ff) ? need : left_ff;
   assign bits     = byte_ff >> (4'd8 - take);
   assign acc_sh   = acc_ff << take;
   assign acc_new  = acc_sh | {4'd0, bits};
   assign held_new = held_ff + take;
   assign complete = active && (held_new == width);
   assign stall    = complete && evt_full;
   assign left_after = left_ff - take;

   always_comb begin
      nxt_step = step_ff;
      nxt_item = item_ff;
      nxt_ch   = ch_ff;
      nxt_gr   = gr_ff;
      nxt_sw   = sw_ff;
      nxt_bk   = bk_ff;
      case (step_ff)
         STEP_MDB:  nxt_step = STEP_PRIV;
         STEP_PRIV: begin
            nxt_step = STEP_SCFSI;
            nxt_item = 2'd0;
            nxt_ch   = 1'b0;
         end
         STEP_SCFSI: begin
            if (item_ff == 2'd3) begin
               nxt_item = 2'd0;
               if (stereo_ff && !ch_ff) begin
                  nxt_ch = 1'b1;
               end else begin
                  nxt_ch   = 1'b0;
                  nxt_gr   = 1'b0;
                  nxt_step = STEP_P23;
               end
            end else begin
               nxt_item = item_ff + 2'd1;
            end
         end
         STEP_P23:  nxt_step = STEP_BV;
         STEP_BV:   nxt_step = STEP_GAIN;
         STEP_GAIN: nxt_step = STEP_SFC;
         STEP_SFC:  nxt_step = STEP_WS;
         STEP_WS: begin
            nxt_sw   = acc_new[0];
            nxt_item = 2'd0;
            if (acc_new[0]) begin
               nxt_step = STEP_BT;
            end else begin
               nxt_bk   = 2'd0;
               nxt_step = STEP_TSEL;
            end
         end
         STEP_BT: begin
            nxt_bk   = acc_new[1:0];
            nxt_step = STEP_MIX;
         end
         STEP_MIX: begin
            nxt_step = STEP_TSEL;
            nxt_item = 2'd0;
         end
         STEP_TSEL: begin
            if (sw_ff && item_ff == 2'd1) begin
               nxt_step = STEP_SBG;
               nxt_item = 2'd0;
            end else if (!sw_ff && item_ff == 2'd2) begin
               nxt_step = STEP_R0;
               nxt_item = 2'd0;
            end else begin
               nxt_item = item_ff + 2'd1;
            end
         end
         STEP_SBG: begin
            if (item_ff == 2'd2) begin
               nxt_step = STEP_PRE;
               nxt_item = 2'd0;
            end else begin
               nxt_item = item_ff + 2'd1;
            end
         end
         STEP_R0:  nxt_step = STEP_R1;
         STEP_R1:  nxt_step = STEP_PRE;
         STEP_PRE: nxt_step = STEP_SFS;
         STEP_SFS: nxt_step = STEP_C1T;
         STEP_C1T: begin
            if (stereo_ff && !ch_ff) begin
               nxt_ch   = 1'b1;
               nxt_step = STEP_P23;
            end else if (!gr_ff) begin
               nxt_gr   = 1'b1;
               nxt_ch   = 1'b0;
               nxt_step = STEP_P23;
            end else begin
               nxt_step = STEP_IDLE;
            end
         end
         default: nxt_step = STEP_IDLE;
      endcase
   end

   always_comb begin
      last_of_byte = (nxt_step == STEP_IDLE) ||
                     (asip_field_width(nxt_step, stereo_ff) > left_after);
      evt_push       = complete && !evt_full;
      evt_data.step  = step_ff;
      evt_data.value = acc_new;
      evt_data.gr    = gr_ff;
      evt_data.ch    = ch_ff;
      evt_data.item  = item_ff;
      evt_data.sw    = sw_ff;
      evt_data.bk    = bk_ff;
      evt_data.last  = last_of_byte;
      evt_data.fdone = (step_ff == STEP_C1T) && !(stereo_ff && !ch_ff) && gr_ff;
      req_tready     = (step_ff == STEP_IDLE) || (left_ff == 4'd0) ||
                       (active && !stall &&
                        ((take == left_ff) || (complete && nxt_step == STEP_IDLE)));
   end

   always_comb begin
      step_in   = step_ff;
      acc_in    = acc_ff;
      held_in   = held_ff;
      stereo_in = stereo_ff;
      gr_in     = gr_ff;
      ch_in     = ch_ff;
      sw_in     = sw_ff;
      bk_in     = bk_ff;
      item_in   = item_ff;
      byte_in   = byte_ff;
      left_in   = left_ff;
      if (active && !stall) begin
         byte_in = byte_ff << take;
         left_in = left_after;
         if (complete) begin
            acc_in  = 12'd0;
            held_in = 4'd0;
            step_in = nxt_step;
            gr_in   = nxt_gr;
            ch_in   = nxt_ch;
            sw_in   = nxt_sw;
            bk_in   = nxt_bk;
            item_in = nxt_item;
            if (nxt_step == STEP_IDLE) begin
               left_in = 4'd0;
            end
         end else begin
            acc_in  = acc_new;
            held_in = held_new;
         end
      end
      if (req_tvalid && req_tready) begin
         if (req_tuser[0]) begin
            step_in   = STEP_MDB;
            stereo_in = req_tuser[1];
            acc_in    = 12'd0;
            held_in   = 4'd0;
            gr_in     = 1'b0;
            ch_in     = 1'b0;
            sw_in     = 1'b0;
            bk_in     = 2'd0;
            item_in   = 2'd0;
            byte_in   = req_tdata;
            left_in   = 4'd8;
         end else if (step_in != STEP_IDLE) begin
            byte_in = req_tdata;
            left_in = 4'd8;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= STEP_IDLE;
         acc_ff    <= 12'd0;
         held_ff   <= 4'd0;
         stereo_ff <= 1'b0;
         gr_ff     <= 1'b0;
         ch_ff     <= 1'b0;
         sw_ff     <= 1'b0;
         bk_ff     <= 2'd0;
         item_ff   <= 2'd0;
         left_ff   <= 4'd0;
      end else begin
         step_ff   <= step_in;
         acc_ff    <= acc_in;
         held_ff   <= held_in;
         stereo_ff <= stereo_in;
         gr_ff     <= gr_in;
         ch_ff     <= ch_in;
         sw_ff     <= sw_in;
         bk_ff     <= bk_in;
         item_ff   <= item_in;
         left_ff   <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

// File: hw/rtl/asip_fifo.sv
// Short queue of completed fields between the front and back ends.
module asip_fifo
   import asip_pkg::*;
#(
   parameter int DEPTH = ASIP_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  fld_evt_type push_data,
   output logic        full,
   input  logic        pop,
   output fld_evt_type head,
   output logic        empty
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   fld_evt_type store_ff [DEPTH];
   logic [IDX_W-1:0] wr_ff, wr_in;
   logic [IDX_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign head    = store_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/asip_back.sv
// Back end: expands each queued field into result transfers, one per cycle while rsp_tready does not stall them.
module asip_back
   import asip_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  fld_evt_type head,
   input  logic        empty,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   output logic        rsp_tuser,
   output logic        rsp_tlast
);

   logic [2:0]   k_ff, k_in;
   logic         valid_ff, valid_in;
   logic [23:0]  data_ff, data_in;
   logic         bdone_ff, bdone_in;
   logic         fdone_ff, fdone_in;

   logic [2:0]   cnt;
   logic         load;
   logic         take_item;
   logic         last_k;
   rsp_item_type res;

   assign cnt       = asip_count(head);
   assign res       = asip_result(head, k_ff);
   assign load      = !valid_ff || rsp_tready;
   assign take_item = load && !empty;
   assign last_k    = (k_ff == cnt - 3'd1);
   assign pop       = take_item && last_k;

   always_comb begin
      k_in     = k_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      bdone_in = bdone_ff;
      fdone_in = fdone_ff;
      if (take_item) begin
         k_in     = last_k ? 3'd0 : k_ff + 3'd1;
         valid_in = 1'b1;
         data_in  = {2'b00, res.value, res.sub, res.id, res.ch, res.gr};
         bdone_in = head.last && last_k;
         fdone_in = res.fdone;
      end else if (load) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         k_ff     <= k_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      bdone_ff <= bdone_in;
      fdone_ff <= fdone_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = bdone_ff;
   assign rsp_tlast  = fdone_ff;

endmodule

// File: hw/rtl/audio_side_info_parser_top.sv
// Top level of the MPEG-1 Layer III side-information parser.
//
//   channel   direction   tdata                                     tuser / tlast
//   req_      in          data_byte[7:0]                            frame_start, stereo_mode
//   rsp_      out         granule, channel, field_id, sub_index,    byte_done / frame_done
//                         field_value
//
// The front end slices a byte one field segment at a time; the back end delivers one result
// transfer per cycle from its output register while rsp_tready does not hold it.
// A byte enters in the cycle its predecessor's last bits are consumed.
// Reset is synchronous; the parser then ignores bytes until one arrives with frame_start.
// A stalled result side fills the field queue and then holds the front end and req_tready.
module audio_side_info_parser_top
   import asip_pkg::*;
#(
   parameter int QUEUE_DEPTH = ASIP_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [0] frame_start, [1] stereo_mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [0] granule, [1] channel, [6:2] field_id,
                                    // [8:7] sub_index, [21:9] field_value, [23:22] zero
   output logic        rsp_tuser,   // [0] byte_done
   output logic        rsp_tlast
);

   fld_evt_type push_data;
   fld_evt_type head;
   logic        push;
   logic        full;
   logic        pop;
   logic        empty;

   asip_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .evt_push   (push),
      .evt_data   (push_data),
      .evt_full   (full)
   );

   asip_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .head      (head),
      .empty     (empty)
   );

   asip_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: hw/rtl/asip_checker.sv
// Port-level assertions for the side-information parser, bound to the top level.
module asip_checker
   import asip_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Result transfer dropped or changed while stalled.");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result valid right after reset.");

   a_last_ends_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("Frame end not marked as the end of its byte.");

   a_last_field: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> (rsp_tdata[6:2] == FID_C1T) && rsp_tdata[0])
      else $error("Frame end on a field other than the second granule's count1 table.");

endmodule

bind audio_side_info_parser_top asip_checker u_asip_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
